// File: rtl/mipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_pkg: shared definitions for the masked instruction pattern decoder
// Action and status codes, default sizes, controller state and the command
// and status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package mipd_pkg;

    // Default table geometry
    localparam int TABLE_ENTRIES_DEF  = 64;
    localparam int MAX_EXCEPTIONS_DEF = 4;

    // Fixed field widths
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int SLOT_W     = 2;
    localparam int WORD_W     = 32;
    localparam int TOTAL_IN_W = 3;
    localparam int STATUS_W   = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE_ENTRY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_EXCEPT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DECODE       = 2'd2;

    // Decode status codes
    localparam logic [STATUS_W-1:0] ST_MATCHED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AMBIGUOUS = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_LOAD
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic ready;   // input channel may take an item
        logic write;   // accepted item is a table write (or ignored action)
        logic start;   // accepted item is a decode: latch it, clear the scan
        logic issue;   // read the current scan entry
        logic load;    // move the scan result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;   // an input item is offered
        logic in_decode;  // the offered item is a decode
        logic scan_last;  // current scan entry is the last one
        logic out_free;   // output register can take a result this cycle
    } ctrl_status_t;

endpackage

// File: rtl/mipd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_req_if: input channel of the decoder
// Carries table writes and decode requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mipd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  entry_index;
    logic [1:0]  exception_slot;
    logic [31:0] ones_pattern;
    logic [31:0] zeros_pattern;
    logic [2:0]  exception_total;
    logic        entry_enable;
    logic [31:0] instruction;
    logic [31:0] fetch_pc;

    modport source (
        output valid, action, entry_index, exception_slot, ones_pattern,
               zeros_pattern, exception_total, entry_enable, instruction, fetch_pc,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, exception_slot, ones_pattern,
               zeros_pattern, exception_total, entry_enable, instruction, fetch_pc,
        output ready
    );
endinterface

// File: rtl/mipd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_rsp_if: result channel of the decoder
// Carries one decode result per decode item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mipd_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  op_index;
    logic [1:0]  decode_status;
    logic [31:0] instruction_out;
    logic [31:0] pc_out;

    modport source (
        output valid, op_index, decode_status, instruction_out, pc_out,
        input  ready
    );

    modport sink (
        input  valid, op_index, decode_status, instruction_out, pc_out,
        output ready
    );
endinterface

// File: rtl/mipd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_ram: generic single-port RAM
// One write and one read per cycle at a shared address, registered read data.
// ----------------------------------------------------------------------------
module mipd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mipd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_ctrl: decoder controller
// Takes items while idle, walks the table once per decode item and hands the
// result to the output register when it is free.
// ----------------------------------------------------------------------------
module mipd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mipd_pkg::ctrl_status_t  status,
    output mipd_pkg::ctrl_cmd_t     cmd
);
    import mipd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (status.in_valid && status.in_decode)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.write = status.in_valid && !status.in_decode;
                cmd.start = status.in_valid && status.in_decode;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            S_DRAIN:
            begin
                cmd = '0;
            end
            S_LOAD:
            begin
                cmd.load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/mipd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_datapath: pattern table, scan pipeline and output register
// Stores entry masks and exception pairs in RAMs, evaluates one entry per
// cycle during a scan and keeps the lowest hit and a saturating hit count.
// ----------------------------------------------------------------------------
module mipd_datapath #(
    parameter int TABLE_ENTRIES  = mipd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_EXCEPTIONS = mipd_pkg::MAX_EXCEPTIONS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    mipd_req_if.sink                req,
    mipd_rsp_if.source              rsp,
    input  mipd_pkg::ctrl_cmd_t     cmd,
    output mipd_pkg::ctrl_status_t  status
);
    import mipd_pkg::*;

    localparam int AW      = $clog2(TABLE_ENTRIES);
    localparam int TW      = $clog2(MAX_EXCEPTIONS + 1);
    localparam int PAIR_W  = 2 * WORD_W;
    localparam int SLOT_RW = PAIR_W + TW;

    // Write decode
    logic                 idx_ok;
    logic [AW-1:0]        waddr;
    logic [TW-1:0]        total_sat;
    logic                 entry_we;
    logic [MAX_EXCEPTIONS-1:0] exc_we;
    logic [AW-1:0]        ram_addr;

    // Table storage
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [SLOT_RW-1:0]   slot_rd;
    logic [PAIR_W-1:0]    exc_rd [MAX_EXCEPTIONS];

    // Scan state
    logic [AW-1:0]        cnt_reg;
    logic [AW-1:0]        cnt_next;
    logic                 eval_en_reg;
    logic [AW-1:0]        eval_idx_reg;
    logic [AW-1:0]        first_reg;
    logic [AW-1:0]        first_next;
    logic [1:0]           hits_reg;
    logic [1:0]           hits_next;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    pc_reg;

    // Evaluation
    logic [WORD_W-1:0]    slot_ones;
    logic [WORD_W-1:0]    slot_zeros;
    logic [TW-1:0]        slot_total;
    logic                 exc_block;
    logic                 entry_hit;

    // Output register
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   op_index_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [WORD_W-1:0]    instr_out_reg;
    logic [WORD_W-1:0]    pc_out_reg;
    logic [STATUS_W-1:0]  status_code;

    function automatic logic pattern_hits(
        input logic [WORD_W-1:0] ones,
        input logic [WORD_W-1:0] zeros,
        input logic [WORD_W-1:0] word
    );
        return ((word & ones) == ones) && ((~word & zeros) == zeros);
    endfunction

    // Decode write items
    assign idx_ok    = 32'(req.entry_index) < 32'(TABLE_ENTRIES);
    assign waddr     = AW'(req.entry_index);
    assign total_sat = (32'(req.exception_total) > 32'(MAX_EXCEPTIONS))
                       ? TW'(MAX_EXCEPTIONS) : TW'(req.exception_total);
    assign entry_we  = cmd.write && (req.action == ACT_WRITE_ENTRY) && idx_ok;

    always_comb
    begin
        for (int k = 0; k < MAX_EXCEPTIONS; k++)
        begin
            exc_we[k] = cmd.write && (req.action == ACT_WRITE_EXCEPT) && idx_ok
                        && (32'(req.exception_slot) == 32'(k));
        end
    end

    // Share the RAM port between writes and the scan
    assign ram_addr = cmd.issue ? cnt_reg : waddr;

    mipd_ram #(
        .WIDTH (SLOT_RW),
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (entry_we),
        .addr  (ram_addr),
        .wdata ({req.ones_pattern, req.zeros_pattern, total_sat}),
        .rdata (slot_rd)
    );

    for (genvar g = 0; g < MAX_EXCEPTIONS; g++)
    begin : g_exc
        mipd_ram #(
            .WIDTH (PAIR_W),
            .DEPTH (TABLE_ENTRIES)
        ) u_exc_ram (
            .clk   (clk),
            .we    (exc_we[g]),
            .addr  (ram_addr),
            .wdata ({req.ones_pattern, req.zeros_pattern}),
            .rdata (exc_rd[g])
        );
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (entry_we)
        begin
            valid_reg[waddr] <= req.entry_enable;
        end
    end

    // Evaluate the entry read in the previous cycle
    assign slot_ones  = slot_rd[SLOT_RW-1 -: WORD_W];
    assign slot_zeros = slot_rd[TW +: WORD_W];
    assign slot_total = slot_rd[TW-1:0];

    always_comb
    begin
        exc_block = 1'b0;
        for (int k = 0; k < MAX_EXCEPTIONS; k++)
        begin
            if ((TW'(k) < slot_total)
                && pattern_hits(exc_rd[k][PAIR_W-1 -: WORD_W],
                                exc_rd[k][WORD_W-1:0], word_reg))
            begin
                exc_block = 1'b1;
            end
        end
    end

    assign entry_hit = eval_en_reg && valid_reg[eval_idx_reg]
                       && pattern_hits(slot_ones, slot_zeros, word_reg) && !exc_block;

    // Advance scan counter and accumulate hits
    always_comb
    begin
        cnt_next   = cnt_reg;
        first_next = first_reg;
        hits_next  = hits_reg;
        if (cmd.start)
        begin
            cnt_next  = '0;
            hits_next = 2'd0;
        end
        else
        begin
            if (cmd.issue)
            begin
                cnt_next = cnt_reg + AW'(1);
            end
            if (entry_hit)
            begin
                if (hits_reg == 2'd0)
                begin
                    first_next = eval_idx_reg;
                end
                if (hits_reg != 2'd2)
                begin
                    hits_next = hits_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            hits_reg    <= 2'd0;
            eval_en_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            hits_reg    <= hits_next;
            eval_en_reg <= cmd.issue;
        end
    end

    // Hold scan payload
    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        eval_idx_reg <= cnt_reg;
        if (cmd.start)
        begin
            word_reg <= req.instruction;
            pc_reg   <= req.fetch_pc;
        end
    end

    // Map the hit count to a status code
    always_comb
    begin
        case (hits_reg)
            2'd0:    status_code = ST_NO_MATCH;
            2'd1:    status_code = ST_MATCHED;
            default: status_code = ST_AMBIGUOUS;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_index_reg  <= (hits_reg == 2'd0) ? '0 : INDEX_W'(first_reg);
            status_reg    <= status_code;
            instr_out_reg <= word_reg;
            pc_out_reg    <= pc_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.op_index        = op_index_reg;
    assign rsp.decode_status   = status_reg;
    assign rsp.instruction_out = instr_out_reg;
    assign rsp.pc_out          = pc_out_reg;

    assign req.ready = cmd.ready;

    // Status to the controller
    assign status.in_valid  = req.valid;
    assign status.in_decode = (req.action == ACT_DECODE);
    assign status.scan_last = (cnt_reg == AW'(TABLE_ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || rsp.ready;

endmodule

// File: rtl/masked_instruction_pattern_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_instruction_pattern_decoder_top: masked instruction pattern decoder
// Table write items are accepted whenever the controller is idle. A decode
// item walks the table one entry per cycle, then its result is loaded into
// the output register once that register is free; no further item is taken
// until the result is loaded.
// Reset clears all entry valid bits and the control state; no clearing pass.
// ----------------------------------------------------------------------------
module masked_instruction_pattern_decoder_top #(
    parameter int TABLE_ENTRIES  = mipd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_EXCEPTIONS = mipd_pkg::MAX_EXCEPTIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mipd_req_if.sink    req,
    mipd_rsp_if.source  rsp
);
    import mipd_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    mipd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mipd_datapath #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .MAX_EXCEPTIONS (MAX_EXCEPTIONS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

    // Never overwrite a result that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!rsp.valid || rsp.ready))
        else $error("result loaded over a pending item");

    // Accepting a decode item closes the input
    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.action == ACT_DECODE) |=> !req.ready)
        else $error("input open during a scan");

    // No match reports index zero
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.decode_status == ST_NO_MATCH) |-> (rsp.op_index == '0))
        else $error("nonzero index without a match");

    // Status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.decode_status == ST_MATCHED
                       || rsp.decode_status == ST_NO_MATCH
                       || rsp.decode_status == ST_AMBIGUOUS))
        else $error("undefined decode status");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: masked instruction pattern decoder
// Loads entry and exception patterns through the request channel and decodes
// instruction words against them. A behavioral copy of the pattern table
// predicts the index, status and pass-through fields of every decode. Each
// response is checked in order against that prediction. Both channels idle
// and stall at random, and one long response hold-off backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import mipd_pkg::*;

    localparam int N_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int MAX_EXC      = MAX_EXCEPTIONS_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_LIMIT  = 50000;

    // Action code that the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0]   action;
        logic [INDEX_W-1:0]    entry_index;
        logic [SLOT_W-1:0]     exception_slot;
        logic [WORD_W-1:0]     ones_pattern;
        logic [WORD_W-1:0]     zeros_pattern;
        logic [TOTAL_IN_W-1:0] exception_total;
        logic                  entry_enable;
        logic [WORD_W-1:0]     instruction;
        logic [WORD_W-1:0]     fetch_pc;
    } request_item_t;

    typedef struct {
        logic [INDEX_W-1:0]  op_index;
        logic [STATUS_W-1:0] decode_status;
        logic [WORD_W-1:0]   instruction_out;
        logic [WORD_W-1:0]   pc_out;
    } decode_result_t;

    logic clk;
    logic rst_n;

    mipd_req_if req_ch ();
    mipd_rsp_if rsp_ch ();

    masked_instruction_pattern_decoder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the pattern table
    bit              tbl_valid [N_ENTRIES];
    bit [WORD_W-1:0] tbl_ones  [N_ENTRIES];
    bit [WORD_W-1:0] tbl_zeros [N_ENTRIES];
    int unsigned     tbl_total [N_ENTRIES];
    bit [WORD_W-1:0] exc_ones    [N_ENTRIES * MAX_EXC];
    bit [WORD_W-1:0] exc_zeros   [N_ENTRIES * MAX_EXC];
    bit              exc_written [N_ENTRIES * MAX_EXC];

    decode_result_t pending_decodes[$];

    int error_count       = 0;
    int items_sent        = 0;
    int burst_left        = 0;
    bit sender_steady     = 0;
    int rsp_hold_request  = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit pattern_hits(bit [WORD_W-1:0] ones, bit [WORD_W-1:0] zeros,
                                        bit [WORD_W-1:0] word);
        return ((word & ones) == ones) && ((~word & zeros) == zeros);
    endfunction

    // Force a word to satisfy a ones/zeros pair
    function automatic bit [WORD_W-1:0] apply_pattern(bit [WORD_W-1:0] word,
                                                       bit [WORD_W-1:0] ones,
                                                       bit [WORD_W-1:0] zeros);
        return (word | ones) & ~zeros;
    endfunction

    function automatic bit [WORD_W-1:0] sparse_word(int unsigned depth);
        bit [WORD_W-1:0] w;
        w = $urandom;
        repeat (depth) w &= $urandom;
        return w;
    endfunction

    // Lowest matching entry, match count and pass-through fields
    function automatic decode_result_t decode_lookup(bit [WORD_W-1:0] word,
                                                     bit [WORD_W-1:0] pc);
        decode_result_t r;
        int unsigned hits;
        bit hit;
        hits = 0;
        r.op_index = '0;
        for (int e = 0; e < N_ENTRIES; e++)
        begin
            hit = tbl_valid[e] && pattern_hits(tbl_ones[e], tbl_zeros[e], word);
            for (int k = 0; k < tbl_total[e]; k++)
                if (pattern_hits(exc_ones[e*MAX_EXC+k], exc_zeros[e*MAX_EXC+k], word))
                    hit = 1'b0;
            if (hit)
            begin
                if (hits == 0)
                    r.op_index = INDEX_W'(e);
                hits++;
            end
        end
        r.decode_status   = (hits == 0) ? ST_NO_MATCH : (hits == 1) ? ST_MATCHED : ST_AMBIGUOUS;
        r.instruction_out = word;
        r.pc_out          = pc;
        return r;
    endfunction

    // Update the shadow table, or queue a decode result, for one accepted item
    function automatic void apply_item(request_item_t it);
        int a;
        a = it.entry_index * MAX_EXC + it.exception_slot;
        case (it.action)
            ACT_WRITE_ENTRY:
            begin
                tbl_ones[it.entry_index]  = it.ones_pattern;
                tbl_zeros[it.entry_index] = it.zeros_pattern;
                tbl_total[it.entry_index] =
                    (it.exception_total > MAX_EXC) ? MAX_EXC : it.exception_total;
                tbl_valid[it.entry_index] = it.entry_enable;
            end
            ACT_WRITE_EXCEPT:
            begin
                exc_ones[a]    = it.ones_pattern;
                exc_zeros[a]   = it.zeros_pattern;
                exc_written[a] = 1'b1;
            end
            ACT_DECODE:
                pending_decodes.push_back(decode_lookup(it.instruction, it.fetch_pc));
            default: ;
        endcase
    endfunction

    // Item with random values in every field
    function automatic request_item_t noise_item();
        request_item_t it;
        it.action          = ACTION_W'($urandom);
        it.entry_index     = INDEX_W'($urandom);
        it.exception_slot  = SLOT_W'($urandom);
        it.ones_pattern    = $urandom;
        it.zeros_pattern   = $urandom;
        it.exception_total = TOTAL_IN_W'($urandom);
        it.entry_enable    = 1'($urandom);
        it.instruction     = $urandom;
        it.fetch_pc        = $urandom;
        return it;
    endfunction

    // Offer one item, idling between bursts, and hold it until accepted
    task automatic send_item(request_item_t it);
        int gap;
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        req_ch.valid           <= 1'b1;
        req_ch.action          <= it.action;
        req_ch.entry_index     <= it.entry_index;
        req_ch.exception_slot  <= it.exception_slot;
        req_ch.ones_pattern    <= it.ones_pattern;
        req_ch.zeros_pattern   <= it.zeros_pattern;
        req_ch.exception_total <= it.exception_total;
        req_ch.entry_enable    <= it.entry_enable;
        req_ch.instruction     <= it.instruction;
        req_ch.fetch_pc        <= it.fetch_pc;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_item(it);
        if (it.action != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic write_exception(bit [INDEX_W-1:0] idx, bit [SLOT_W-1:0] slot,
                                   bit [WORD_W-1:0] ones, bit [WORD_W-1:0] zeros);
        request_item_t it;
        it = noise_item();
        it.action         = ACT_WRITE_EXCEPT;
        it.entry_index    = idx;
        it.exception_slot = slot;
        it.ones_pattern   = ones;
        it.zeros_pattern  = zeros;
        send_item(it);
    endtask

    // Write an entry; fill any exception pair it will use that was never written
    task automatic write_entry(bit [INDEX_W-1:0] idx, bit [WORD_W-1:0] ones,
                               bit [WORD_W-1:0] zeros, bit [TOTAL_IN_W-1:0] total,
                               bit enable);
        request_item_t it;
        int in_use;
        in_use = (total > MAX_EXC) ? MAX_EXC : total;
        if (enable)
            for (int k = 0; k < in_use; k++)
                if (!exc_written[idx*MAX_EXC+k])
                    write_exception(idx, SLOT_W'(k), sparse_word($urandom_range(2, 4)),
                                    sparse_word($urandom_range(2, 4)));
        it = noise_item();
        it.action          = ACT_WRITE_ENTRY;
        it.entry_index     = idx;
        it.ones_pattern    = ones;
        it.zeros_pattern   = zeros;
        it.exception_total = total;
        it.entry_enable    = enable;
        send_item(it);
    endtask

    task automatic decode(bit [WORD_W-1:0] word, bit [WORD_W-1:0] pc);
        request_item_t it;
        it = noise_item();
        it.action      = ACT_DECODE;
        it.instruction = word;
        it.fetch_pc    = pc;
        send_item(it);
    endtask

    task automatic send_unused();
        request_item_t it;
        it = noise_item();
        it.action = ACT_UNUSED;
        send_item(it);
    endtask

    task automatic write_random_entry();
        bit [WORD_W-1:0] ones;
        bit [WORD_W-1:0] zeros;
        ones  = sparse_word($urandom_range(1, 4));
        zeros = sparse_word($urandom_range(1, 4));
        if ($urandom_range(0, 9) != 0)
            zeros &= ~ones;
        if ($urandom_range(0, 19) == 0)
        begin
            ones  = $urandom;
            zeros = $urandom;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            ones  = '0;
            zeros = '0;
        end
        write_entry(INDEX_W'($urandom), ones, zeros, TOTAL_IN_W'($urandom),
                    $urandom_range(0, 4) != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_table();
        decode(32'h0000_0000, 32'h0000_0000);
        decode(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_single_match();
        write_entry(6'd0, 32'h0000_0013, 32'h0000_0060, 3'd0, 1'b1);
        write_entry(6'd63, 32'hFFFF_FFFF, 32'h0000_0000, 3'd0, 1'b1);
        decode(32'h0000_0013, 32'h0000_1000);
        decode(32'hFFFF_FFFF, 32'h8000_0004);
        decode(32'h0000_0073, 32'h7FFF_FFFC);
    endtask

    task automatic test_exceptions();
        // Exception total above the limit saturates
        write_entry(6'd1, 32'h0000_0000, 32'hFFFF_0000, 3'd7, 1'b1);
        write_exception(6'd1, 2'd3, 32'h0000_00F0, 32'h0000_0000);
        decode(32'h0000_00F0, 32'h0000_2000);
        decode(32'h0000_0001, 32'h0000_2004);
        // Exception write leaves an invalid entry invalid
        write_exception(6'd10, 2'd0, 32'h0000_0000, 32'h0000_0000);
        decode(32'h0000_0000, 32'h0000_2008);
    endtask

    task automatic test_ambiguous();
        write_entry(6'd5, 32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1);
        write_entry(6'd9, 32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1);
        decode(32'h1234_5678, 32'h0000_3000);
        write_entry(6'd5, 32'h0000_0000, 32'h0000_0000, 3'd0, 1'b0);
        write_entry(6'd9, 32'h0000_0000, 32'h0000_0000, 3'd0, 1'b0);
        decode(32'h1234_5678, 32'h0000_3004);
    endtask

    task automatic test_unused_action();
        send_unused();
        send_unused();
        decode(32'h0000_0013, 32'h0000_4000);
    endtask

    // Hold off the response side while decodes keep coming
    task automatic test_backpressure();
        sender_steady    = 1'b1;
        rsp_hold_request = 700;
        repeat (20) decode($urandom, $urandom);
        sender_steady    = 1'b0;
    endtask

    task automatic test_random_traffic();
        int live[$];
        int a;
        int b;
        int k;
        int sel;
        int start_count;
        bit [WORD_W-1:0] word;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            live.delete();
            for (int e = 0; e < N_ENTRIES; e++)
                if (tbl_valid[e])
                    live.push_back(e);
            sel = $urandom_range(0, 99);
            if (live.size() < 6 && sel < 50)
                sel = 0;
            if (sel < 9)
                write_random_entry();
            else if (sel < 17)
                write_exception(INDEX_W'($urandom), SLOT_W'($urandom),
                                sparse_word($urandom_range(2, 4)),
                                sparse_word($urandom_range(2, 4)));
            else if (sel < 21)
                send_unused();
            else
            begin
                word = $urandom;
                if (live.size() > 0 && sel < 85)
                begin
                    a = live[$urandom_range(0, live.size() - 1)];
                    word = apply_pattern(word, tbl_ones[a], tbl_zeros[a]);
                    if (sel >= 50 && sel < 65)
                    begin
                        // aim at two entries at once
                        b = live[$urandom_range(0, live.size() - 1)];
                        word = apply_pattern(word, tbl_ones[b], tbl_zeros[b]);
                    end
                    else if (sel >= 65 && tbl_total[a] > 0)
                    begin
                        // aim at one of the entry's exceptions
                        k = a * MAX_EXC + $urandom_range(0, tbl_total[a] - 1);
                        word = apply_pattern(word, exc_ones[k], exc_zeros[k]);
                    end
                end
                else if (sel >= 95)
                    word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                decode(word, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: stall pattern, hold-off and result check
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [WORD_W-1:0] expv, logic [WORD_W-1:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
            error_count++;
        end
    endtask

    initial
    begin
        decode_result_t exp_r;
        bit [31:0] stall_bits;
        int stall_age;
        int hold_left;
        stall_bits = '1;
        stall_age  = 0;
        hold_left  = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // Check an accepted result against the oldest prediction
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_decodes.size() == 0)
                begin
                    $error("result with no decode pending: op_index %0d status %0d",
                           rsp_ch.op_index, rsp_ch.decode_status);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_decodes.pop_front();
                    check_field("op_index", WORD_W'(exp_r.op_index),
                                WORD_W'(rsp_ch.op_index));
                    check_field("decode_status", WORD_W'(exp_r.decode_status),
                                WORD_W'(rsp_ch.decode_status));
                    check_field("instruction_out", exp_r.instruction_out,
                                rsp_ch.instruction_out);
                    check_field("pc_out", exp_r.pc_out, rsp_ch.pc_out);
                end
            end
            // Pick up a requested hold-off
            if (rsp_hold_request > 0)
            begin
                hold_left        = rsp_hold_request;
                rsp_hold_request = 0;
            end
            // Reload the stall pattern now and then; sometimes no stalls at all
            if (stall_age == 0)
            begin
                stall_age  = 64;
                stall_bits = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
            end
            stall_age--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[31:1]};
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int drain_wait;
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.action          <= ACT_WRITE_ENTRY;
        req_ch.entry_index     <= '0;
        req_ch.exception_slot  <= '0;
        req_ch.ones_pattern    <= '0;
        req_ch.zeros_pattern   <= '0;
        req_ch.exception_total <= '0;
        req_ch.entry_enable    <= 1'b0;
        req_ch.instruction     <= '0;
        req_ch.fetch_pc        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_single_match();
        test_exceptions();
        test_ambiguous();
        test_unused_action();
        test_backpressure();
        test_random_traffic();
        req_ch.valid <= 1'b0;

        // Drain outstanding decodes, then allow one more scan time
        drain_wait = 0;
        while (pending_decodes.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (N_ENTRIES + 8) @(posedge clk);
        if (pending_decodes.size() != 0)
        begin
            $error("%0d decode results never arrived", pending_decodes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
